### hdl/assert_macros.svh
// assertion macros shared by the cipher rtl
// clocked on clk_i and disabled while rst_ni is low; empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/xtea_pkg.sv
// shared types, constants and round helpers for the xtea cipher unit
// no dependencies
package xtea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CntW    = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WordW-1:0] XteaDelta       = 32'h9E3779B9;
  localparam logic [WordW-1:0] KeyReset0       = 32'hA56BABCD;
  localparam logic [WordW-1:0] KeyReset1       = 32'h56781234;
  localparam logic [WordW-1:0] KeyReset2       = 32'hDEF91234;
  localparam logic [WordW-1:0] KeyReset3       = 32'h12345678;
  localparam logic [CntW-1:0]  CycleCountReset = 7'd32;
  // delta times the reset cycle count, modulo 2^32
  localparam logic [WordW-1:0] DecSumReset =
      WordW'(64'(XteaDelta) * 64'(CycleCountReset));

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0   = 3'd0,
    CfgKey1   = 3'd1,
    CfgKey2   = 3'd2,
    CfgKey3   = 3'd3,
    CfgCycles = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ModeEncipher = 1'b0,
    ModeDecipher = 1'b1
  } mode_e;

  typedef logic [3:0][WordW-1:0] key_t;

  // request payload
  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] block_hi;
    logic [WordW-1:0] block_lo;
  } xtea_in_t;

  // result payload
  typedef struct packed {
    logic [WordW-1:0] result_hi;
    logic [WordW-1:0] result_lo;
  } xtea_out_t;

  // block state carried around the cell ring
  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
    logic [CntW-1:0]  cnt;
  } xtea_token_t;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // half-round term added to or subtracted from the other half
  function automatic logic [WordW-1:0] feistel(input logic [WordW-1:0] v,
                                               input logic [WordW-1:0] sum,
                                               input logic [WordW-1:0] key);
    return mix(v) ^ (sum + key);
  endfunction

endpackage

### hdl/xtea_block_cipher_unit.sv
// top level of the xtea cipher unit: config registers, cell ring, result register
// depends on xtea_pkg, xtea_cell and assert_macros.svh
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | to unit   | in_valid_i / in_stall_o  | in_data_i  (mode, block halves)
//  out      | from unit | out_valid_o / out_stall_i| out_data_o (result halves)
//  cfg      | to unit   | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
//  a block runs one xtea cycle per clock as it moves from cell to cell round the ring
//  a block leaves the ring for the result register once its cycle count is spent, and
//  the next request is taken only once the result register has taken that block
//  one block at a time is in the ring; a waiting result does not block the next request
//  a stalled output holds the finished block in the ring until the register frees up
//  reset restores the default key and cycle count and empties the ring
`include "assert_macros.svh"

module xtea_block_cipher_unit import xtea_pkg::*; #(
  parameter int unsigned NUM_CELLS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  xtea_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xtea_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i
);

  key_t             key_q;
  logic [CntW-1:0]  cycles_q;
  logic [WordW-1:0] dec_sum_q;
  logic             busy_q;
  logic             out_valid_q;
  xtea_out_t        out_data_q;

  logic                 accept;
  logic                 take;
  xtea_token_t          load_tok;
  xtea_token_t          ring_tok [NUM_CELLS];
  xtea_token_t          cell_in  [NUM_CELLS];
  logic [NUM_CELLS-1:0] ring_valid;
  logic [NUM_CELLS-1:0] cell_valid_in;
  logic [NUM_CELLS-1:0] done_vec;
  xtea_out_t            done_data;

  // configuration registers; start sum for deciphering is kept alongside the count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0]  <= KeyReset0;
      key_q[1]  <= KeyReset1;
      key_q[2]  <= KeyReset2;
      key_q[3]  <= KeyReset3;
      cycles_q  <= CycleCountReset;
      dec_sum_q <= DecSumReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgKey0: key_q[0] <= cfg_wdata_i;
        CfgKey1: key_q[1] <= cfg_wdata_i;
        CfgKey2: key_q[2] <= cfg_wdata_i;
        CfgKey3: key_q[3] <= cfg_wdata_i;
        CfgCycles: begin
          cycles_q  <= cfg_wdata_i[CntW-1:0];
          dec_sum_q <= XteaDelta * WordW'(cfg_wdata_i[CntW-1:0]);
        end
        default: ;
      endcase
    end
  end

  // request intake
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  always_comb begin
    load_tok.mode = in_data_i.mode;
    load_tok.v0   = in_data_i.block_hi;
    load_tok.v1   = in_data_i.block_lo;
    load_tok.sum  = (in_data_i.mode == ModeDecipher) ? dec_sum_q : '0;
    load_tok.cnt  = cycles_q;
  end

  // ring wiring: each cell feeds the next, new blocks enter at cell zero
  always_comb begin
    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_in[i]       = ring_tok[(i + NUM_CELLS - 1) % NUM_CELLS];
      cell_valid_in[i] = ring_valid[(i + NUM_CELLS - 1) % NUM_CELLS];
    end
    if (accept) begin
      cell_in[0]       = load_tok;
      cell_valid_in[0] = 1'b1;
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    xtea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid_in[g]),
      .take_i  (take),
      .tok_i   (cell_in[g]),
      .key_i   (key_q),
      .valid_o (ring_valid[g]),
      .tok_o   (ring_tok[g])
    );
  end

  // pick out the finished block, at most one cell holds it
  always_comb begin
    done_data = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      done_vec[i] = ring_valid[i] && (ring_tok[i].cnt == '0);
      if (done_vec[i]) begin
        done_data.result_hi = done_data.result_hi | ring_tok[i].v0;
        done_data.result_lo = done_data.result_lo | ring_tok[i].v1;
      end
    end
  end

  assign take = (|done_vec) && (!out_valid_q || !out_stall_i);

  // ring occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (take) begin
      busy_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= done_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `ASSERT_CLK(a_single_token, $onehot0(ring_valid), "more than one block in the cell ring")
  `ASSERT_CLK(a_busy_matches_ring, busy_q == (|ring_valid), "busy flag and ring occupancy differ")
  `ASSERT_CLK(a_take_loads_result, take |=> out_valid_q, "taken block did not reach result register")
  `ASSERT_NEVER(a_take_over_full, take && out_valid_q && out_stall_i, "result overwritten while stalled")

endmodule

### hdl/xtea_cell.sv
// one ring cell: runs one xtea cycle on the block it receives, unless its count is spent, and registers it
// depends on xtea_pkg
module xtea_cell import xtea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        take_i,
  input  xtea_token_t tok_i,
  input  key_t        key_i,
  output logic        valid_o,
  output xtea_token_t tok_o
);

  logic             valid_q, valid_d;
  xtea_token_t      tok_q, tok_d;
  logic [WordW-1:0] v0_n, v1_n, sum_n;

  // one full cycle (two half-rounds) while cycles remain
  always_comb begin
    v0_n  = tok_i.v0;
    v1_n  = tok_i.v1;
    sum_n = tok_i.sum;
    if (tok_i.mode == ModeDecipher) begin
      v1_n  = tok_i.v1 - feistel(tok_i.v0, tok_i.sum, key_i[tok_i.sum[12:11]]);
      sum_n = tok_i.sum - XteaDelta;
      v0_n  = tok_i.v0 - feistel(v1_n, sum_n, key_i[sum_n[1:0]]);
    end else begin
      v0_n  = tok_i.v0 + feistel(tok_i.v1, tok_i.sum, key_i[tok_i.sum[1:0]]);
      sum_n = tok_i.sum + XteaDelta;
      v1_n  = tok_i.v1 + feistel(v0_n, sum_n, key_i[sum_n[12:11]]);
    end
  end

  // finished blocks pass unchanged until the output side takes them
  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_i && !((tok_i.cnt == '0) && take_i);
    if (tok_i.cnt != '0) begin
      tok_d.v0  = v0_n;
      tok_d.v1  = v1_n;
      tok_d.sum = sum_n;
      tok_d.cnt = tok_i.cnt - 1'b1;
    end
  end

  // token presence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // block state
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

### sim/xtea_block_cipher_checker.sv
// result checker for the xtea cipher unit: watches request, result and register ports
// keeps its own copy of key and cycle count and predicts each block; needs xtea_pkg
module xtea_block_cipher_checker import xtea_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  xtea_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  xtea_out_t          out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  output int                 fail_count,
  output int                 blocks_pending,
  output int                 blocks_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the register file
  logic [WordW-1:0] key_words [4];
  logic [CntW-1:0]  cycles;

  // predicted blocks, oldest first
  xtea_out_t cipher_blocks_due [$];

  initial begin
    fail_count     = 0;
    blocks_pending = 0;
    blocks_checked = 0;
  end

  // one feistel half-round term
  function automatic logic [WordW-1:0] round_term(input logic [WordW-1:0] v,
                                                  input logic [WordW-1:0] s,
                                                  input logic [WordW-1:0] k);
    return (((v << 4) ^ (v >> 5)) + v) ^ (s + k);
  endfunction

  // full xtea pass under the current key and cycle count
  function automatic xtea_out_t xtea_transform(input xtea_in_t req);
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
    xtea_out_t        res;
    v0 = req.block_hi;
    v1 = req.block_lo;
    if (req.mode == ModeEncipher) begin
      sum = '0;
      for (int n = 0; n < int'(cycles); n++) begin
        v0  += round_term(v1, sum, key_words[sum[1:0]]);
        sum += XteaDelta;
        v1  += round_term(v0, sum, key_words[sum[12:11]]);
      end
    end else begin
      // decipher starts from delta times the cycle count, mod 2^32
      sum = XteaDelta * {{(WordW-CntW){1'b0}}, cycles};
      for (int n = 0; n < int'(cycles); n++) begin
        v1  -= round_term(v0, sum, key_words[sum[12:11]]);
        sum -= XteaDelta;
        v0  -= round_term(v1, sum, key_words[sum[1:0]]);
      end
    end
    res.result_hi = v0;
    res.result_lo = v1;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // compare results, predict requests, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    xtea_out_t want;
    if (!rst_ni) begin
      key_words[0] = KeyReset0;
      key_words[1] = KeyReset1;
      key_words[2] = KeyReset2;
      key_words[3] = KeyReset3;
      cycles       = CycleCountReset;
      cipher_blocks_due.delete();
    end else begin
      // result side
      if (out_valid_i && !out_stall_i) begin
        if (cipher_blocks_due.size() == 0) begin
          flag_error($sformatf("result %h_%h with no request outstanding",
                               out_data_i.result_hi, out_data_i.result_lo));
        end else begin
          want = cipher_blocks_due.pop_front();
          blocks_checked++;
          if (out_data_i.result_hi !== want.result_hi) begin
            flag_error($sformatf("result_hi mismatch: expected %h, got %h",
                                 want.result_hi, out_data_i.result_hi));
          end
          if (out_data_i.result_lo !== want.result_lo) begin
            flag_error($sformatf("result_lo mismatch: expected %h, got %h",
                                 want.result_lo, out_data_i.result_lo));
          end
        end
      end
      // request side, predicted with the settings in force before this edge
      if (in_valid_i && !in_stall_i) begin
        cipher_blocks_due.push_back(xtea_transform(in_data_i));
      end
      // register writes; unused indexes change nothing
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKey0:   key_words[0] = cfg_wdata_i;
          CfgKey1:   key_words[1] = cfg_wdata_i;
          CfgKey2:   key_words[2] = cfg_wdata_i;
          CfgKey3:   key_words[3] = cfg_wdata_i;
          CfgCycles: cycles = cfg_wdata_i[CntW-1:0];
          default:   ;
        endcase
      end
    end
    blocks_pending = cipher_blocks_due.size();
  end

endmodule

### sim/tb_xtea_block_cipher_unit.sv
// testbench top for the xtea cipher unit: clock, reset, requests, register writes, verdict
// depends on xtea_pkg, xtea_block_cipher_unit and xtea_block_cipher_checker
module tb_xtea_block_cipher_unit import xtea_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  xtea_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  xtea_out_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = CfgKey0;
  logic [WordW-1:0]   cfg_wdata_i = '0;

  int fail_count;
  int blocks_pending;
  int blocks_checked;

  // idling mix of the current phase, in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  int enc_sent      = 0;
  int dec_sent      = 0;
  int settings_used = 0;

  xtea_block_cipher_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  xtea_block_cipher_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count     (fail_count),
    .blocks_pending (blocks_pending),
    .blocks_checked (blocks_checked)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // random result stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // run limit
  initial begin
    #50ms;
    $display("timeout with %0d blocks outstanding", blocks_pending);
    $display("[xtea_block_cipher_unit] ERROR");
    $finish;
  end

  // one request; entered and left at a falling edge, valid still high on return
  task automatic send_block(input logic m, input logic [WordW-1:0] hi,
                            input logic [WordW-1:0] lo);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_data_i.mode     <= m;
    in_data_i.block_hi <= hi;
    in_data_i.block_lo <= lo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (m == ModeDecipher) dec_sent++;
    else enc_sent++;
  endtask

  // hold off requests until every block has come back
  task automatic drain_ring();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (blocks_pending != 0) @(negedge clk_i);
  endtask

  // single register write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  // full key and cycle count, only while the unit is idle
  task automatic load_settings(input logic [WordW-1:0] k0, input logic [WordW-1:0] k1,
                               input logic [WordW-1:0] k2, input logic [WordW-1:0] k3,
                               input logic [WordW-1:0] cyc_word);
    cfg_write(CfgKey0, k0);
    cfg_write(CfgKey1, k1);
    cfg_write(CfgKey2, k2);
    cfg_write(CfgKey3, k3);
    cfg_write(CfgCycles, cyc_word);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [WordW-1:0] pick_key_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom();
  endfunction

  // stimulus
  initial begin
    int               r;
    logic [WordW-1:0] cyc_word;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset key and default cycles, both modes, extreme blocks
    send_block(ModeEncipher, '0, '0);
    send_block(ModeEncipher, '1, '1);
    send_block(ModeDecipher, '0, '0);
    send_block(ModeDecipher, '1, '1);
    send_block(ModeEncipher, 32'h8000_0000, 32'h0000_0001);
    drain_ring();

    // writes to unused indexes must leave the reset settings alone
    for (int i = int'(CfgCycles) + 1; i < 2 ** CfgIdxW; i++) begin
      cfg_write(CfgIdxW'(i), '1);
    end
    cfg_we_i <= 1'b0;
    send_block(ModeEncipher, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(ModeDecipher, 32'h0123_4567, 32'h89AB_CDEF);
    drain_ring();

    // zero cycles passes the block through unchanged
    load_settings('1, '1, '1, '1, 32'd0);
    send_block(ModeEncipher, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_block(ModeDecipher, 32'hFFFF_0000, 32'h0000_FFFF);
    drain_ring();

    // all-ones write keeps only the low 7 bits, the largest count, beyond the nominal range
    load_settings(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1357_9BDF, 32'h2468_ACE0, '1);
    send_block(ModeEncipher, 32'h7FFF_FFFF, 32'h8000_0000);
    send_block(ModeDecipher, 32'h7FFF_FFFF, 32'h8000_0000);
    drain_ring();

    load_settings(32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd65);
    send_block(ModeEncipher, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(ModeDecipher, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_ring();

    // all-zero key, single cycle
    load_settings('0, '0, '0, '0, 32'd1);
    send_block(ModeEncipher, '1, '1);
    send_block(ModeDecipher, '1, '1);
    drain_ring();

    load_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'd64);
    send_block(ModeEncipher, 32'hCAFE_F00D, 32'h1234_5678);
    send_block(ModeDecipher, 32'hCAFE_F00D, 32'h1234_5678);
    drain_ring();

    // random phases: new settings each phase, idling mix rotates
    for (int phase = 0; phase < 32; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      // mostly short runs, some default and long, a few zero or above range
      r = $urandom_range(99);
      if (r < 55) cyc_word = $urandom_range(8, 1);
      else if (r < 75) cyc_word = 32;
      else if (r < 92) cyc_word = $urandom_range(64, 9);
      else if (r < 96) cyc_word = 0;
      else cyc_word = $urandom_range(127, 65);
      // junk in the upper bits must be dropped
      if ($urandom_range(3) == 0) cyc_word |= $urandom() & ~32'h7F;
      load_settings(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word(),
                    cyc_word);
      for (int n = 0; n < 60; n++) begin
        // sender pause until the unit has emptied
        if (phase % 5 == 2 && n == 30) drain_ring();
        send_block(1'($urandom_range(1)), $urandom(), $urandom());
      end
      drain_ring();
    end

    // let any stray result show up
    idle_pct  = 0;
    stall_pct = 0;
    repeat (140) @(negedge clk_i);

    $display("sent %0d encipher and %0d decipher blocks under %0d key/cycle settings",
             enc_sent, dec_sent, settings_used);
    $display("checked %0d results, %0d errors, %0d left outstanding",
             blocks_checked, fail_count, blocks_pending);
    if (fail_count == 0 && blocks_pending == 0) begin
      $display("[xtea_block_cipher_unit] OK");
    end else begin
      $display("[xtea_block_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule
